>>> sv/ppmfd_pkg.sv
// ============================================================================
// ppmfd_pkg - shared types and constants for the PPM frame decoder
// Item layouts, command codes, register indexes and arithmetic constants.
// ============================================================================
package ppmfd_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int BASE_MHZ     = 48;

  localparam int SLOT_W   = $clog2(MAX_CHANNELS + 1);
  localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(MAX_CHANNELS);
  localparam logic [4:0]        CH_LIMIT   = 5'(MAX_CHANNELS);

  localparam int SYNC_OFFSET_US = 310;
  localparam int SYNC_GAP_US    = 5000;
  localparam int RESET_MIN_US   = 700;
  localparam int RESET_MAX_US   = 1670;
  localparam int PCT_FULL       = 100;
  localparam int PULSE_SAT      = 65535;
  localparam int PULSE_W        = 14;

  localparam logic [7:0] PRESCALER_RESET     = 8'd47;
  localparam logic [3:0] CHANNEL_COUNT_RESET = 4'd8;

  // ticks * (prescaler + 1) fits 24 bits; division by BASE_MHZ is done as a
  // multiply by a rounded-up reciprocal, exact for every 24-bit product
  localparam int PROD_W   = 24;
  localparam int RECIP_L  = $clog2(BASE_MHZ);
  localparam int RECIP_SH = PROD_W + RECIP_L;
  localparam int RECIP_W  = PROD_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SH) / BASE_MHZ + 1);
  localparam int SCALE_W  = PROD_W + RECIP_W;
  localparam int QUO_W    = SCALE_W - RECIP_SH;

  localparam int DIVD_W    = 20;
  localparam int DIVS_W    = 16;
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIVD_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_CAPTURE = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_LIMITS  = 2'd2;

  localparam logic REG_PRESCALER     = 1'b0;
  localparam logic REG_CHANNEL_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_CAPTURE,
    OP_READ,
    OP_LIMITS,
    OP_BAD
  } ppmfd_op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] capture_ticks;
    logic [2:0]  channel_index;
    logic [15:0] limit_min;
    logic [15:0] limit_max;
  } ppmfd_in_t;

  typedef struct packed {
    logic signed [16:0] pulse_us;
    logic [6:0]         percent;
    logic               status;
    logic               frame_start;
  } ppmfd_out_t;

  typedef struct packed {
    ppmfd_op_t           op;
    logic                chan_ok;
    logic                limits_ok;
    logic [CH_IDX_W-1:0] chan;
    logic [15:0]         ticks;
    logic [15:0]         lmin;
    logic [15:0]         lmax;
  } ppmfd_job_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } ppmfd_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } ppmfd_div_rsp_t;

endpackage

>>> sv/ppmfd_front.sv
// ============================================================================
// ppmfd_front - command classifier
// Decodes an incoming item into an operation and checks its arguments.
// ============================================================================
module ppmfd_front import ppmfd_pkg::*; (
  input  ppmfd_in_t  req,
  input  logic [3:0] channel_count,
  output ppmfd_job_t job
);

  always_comb begin
    job.chan_ok   = ({1'b0, req.channel_index} < channel_count) &&
                    ({2'b00, req.channel_index} < CH_LIMIT);
    job.limits_ok = req.limit_min < req.limit_max;
    job.chan      = CH_IDX_W'(req.channel_index);
    job.ticks     = req.capture_ticks;
    job.lmin      = req.limit_min;
    job.lmax      = req.limit_max;
    case (req.command)
      CMD_CAPTURE: job.op = OP_CAPTURE;
      CMD_READ:    job.op = OP_READ;
      CMD_LIMITS:  job.op = OP_LIMITS;
      default:     job.op = OP_BAD;
    endcase
  end

endmodule

>>> sv/ppmfd_queue.sv
// ============================================================================
// ppmfd_queue - short job queue
// Decouples the classifier from the execution unit.
// ============================================================================
module ppmfd_queue import ppmfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  ppmfd_job_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output ppmfd_job_t pop_item
);

  ppmfd_job_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_item;
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/ppmfd_div.sv
// ============================================================================
// ppmfd_div - radix-2 restoring divider
// One quotient bit per cycle; pulses done with the quotient held after.
// ============================================================================
module ppmfd_div import ppmfd_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  ppmfd_div_req_t req,
  output ppmfd_div_rsp_t rsp
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVS_W-1:0]    rem;
  logic [DIVD_W-1:0]    dq;
  logic [DIVS_W-1:0]    divisor;
  logic                 done;
  logic [DIVS_W:0]      shifted;
  logic                 ge;
  logic [DIVS_W-1:0]    rem_next;

  always_comb begin
    shifted  = {rem, dq[DIVD_W-1]};
    ge       = shifted >= {1'b0, divisor};
    rem_next = ge ? DIVS_W'(shifted - {1'b0, divisor}) : shifted[DIVS_W-1:0];
  end

  assign rsp.done     = done;
  assign rsp.quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        dq      <= req.dividend;
        rem     <= '0;
        divisor <= req.divisor;
        cnt     <= DIV_STEPS;
        done    <= 1'b0;
      end else if (cnt != '0) begin
        dq   <= {dq[DIVD_W-2:0], ge};
        rem  <= rem_next;
        cnt  <= cnt - 1'b1;
        done <= cnt == DIV_CNT_W'(1);
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

>>> sv/ppmfd_back.sv
// ============================================================================
// ppmfd_back - execution unit
// Runs one job at a time: scales captures, fills channel slots, reads
// channels with their percentage, writes limits, and drives the result.
// ============================================================================
module ppmfd_back import ppmfd_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  ppmfd_job_t     q_job,
  input  logic [7:0]     prescaler,
  output ppmfd_div_req_t div_req,
  input  ppmfd_div_rsp_t div_rsp,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ppmfd_out_t     rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SCALE,
    S_PREP,
    S_DIV,
    S_FIN
  } state_t;

  state_t                    state;
  ppmfd_job_t                job;
  logic [PROD_W-1:0]         prod;
  logic [QUO_W-1:0]          quo;
  logic [6:0]                pct;
  logic [SLOT_W-1:0]         slot_index;
  logic signed [PULSE_W-1:0] channel_pulse [MAX_CHANNELS];
  logic [15:0]               channel_min   [MAX_CHANNELS];
  logic [15:0]               channel_max   [MAX_CHANNELS];

  logic [8:0]                pre_inc;
  logic [PROD_W:0]           tick_prod;
  logic [SCALE_W-1:0]        scale_full;
  logic signed [QUO_W:0]     us;
  logic                      sync_gap;
  logic signed [PULSE_W-1:0] t;
  logic [15:0]               lo;
  logic [15:0]               hi;
  logic signed [17:0]        num;
  logic [16:0]               den;
  logic                      num_pos;
  logic                      den_pos;
  logic [6:0]                pct_clamp;
  logic                      out_free;
  ppmfd_out_t                res;

  always_comb begin
    pre_inc    = {1'b0, prescaler} + 9'd1;
    tick_prod  = (PROD_W + 1)'(job.ticks) * (PROD_W + 1)'(pre_inc);
    scale_full = SCALE_W'(prod) * SCALE_W'(RECIP);

    us       = $signed({1'b0, quo}) - $signed((QUO_W + 1)'(SYNC_OFFSET_US));
    sync_gap = us > $signed((QUO_W + 1)'(SYNC_GAP_US));

    t       = channel_pulse[job.chan];
    lo      = channel_min[job.chan];
    hi      = channel_max[job.chan];
    num     = $signed(18'(t)) - $signed({2'b00, lo});
    den     = {1'b0, hi} - {1'b0, lo};
    num_pos = !num[17] && (num != '0);
    den_pos = !den[16] && (den != '0);

    div_req.start    = (state == S_PREP) && num_pos && den_pos;
    div_req.dividend = DIVD_W'(num[12:0]) * DIVD_W'(PCT_FULL);
    div_req.divisor  = den[DIVS_W-1:0];

    pct_clamp = (div_rsp.quotient > DIVD_W'(PCT_FULL)) ? 7'(PCT_FULL)
                                                       : div_rsp.quotient[6:0];
    out_free  = !rsp_valid || rsp_ready;

    res = '0;
    case (job.op)
      OP_CAPTURE: begin
        res.frame_start = sync_gap;
        res.pulse_us    = (us > $signed((QUO_W + 1)'(PULSE_SAT)))
                          ? $signed(17'(PULSE_SAT)) : $signed(17'(us));
      end
      OP_READ: begin
        if (job.chan_ok) begin
          res.pulse_us = $signed(17'(t));
          res.percent  = pct;
        end else begin
          res.status = 1'b1;
        end
      end
      OP_LIMITS: res.status = !(job.chan_ok && job.limits_ok);
      default:   res.status = 1'b1;
    endcase
  end

  assign q_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      slot_index <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        channel_pulse[i] <= '0;
        channel_min[i]   <= 16'(RESET_MIN_US);
        channel_max[i]   <= 16'(RESET_MAX_US);
      end
    end else begin
      // S_FIN reloads the result register itself
      if (rsp_valid && rsp_ready && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            job <= q_job;
            case (q_job.op)
              OP_CAPTURE: state <= S_MUL;
              OP_READ:    state <= q_job.chan_ok ? S_PREP : S_FIN;
              default:    state <= S_FIN;
            endcase
          end
        end
        S_MUL: begin
          prod  <= tick_prod[PROD_W-1:0];
          state <= S_SCALE;
        end
        S_SCALE: begin
          quo   <= scale_full[SCALE_W-1:RECIP_SH];
          state <= S_FIN;
        end
        S_PREP: begin
          pct   <= '0;
          state <= div_req.start ? S_DIV : S_FIN;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            pct   <= pct_clamp;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
            case (job.op)
              OP_CAPTURE: begin
                if (sync_gap) begin
                  slot_index <= '0;
                end else if (slot_index < SLOT_LIMIT) begin
                  channel_pulse[slot_index[CH_IDX_W-1:0]] <= $signed(us[PULSE_W-1:0]);
                  slot_index <= slot_index + 1'b1;
                end
              end
              OP_LIMITS: begin
                if (job.chan_ok && job.limits_ok) begin
                  channel_min[job.chan] <= job.lmin;
                  channel_max[job.chan] <= job.lmax;
                end
              end
              default: ;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/ppm_frame_decoder.sv
// ============================================================================
// ppm_frame_decoder - PPM radio-control frame decoder
// Turns capture intervals into channel pulse widths and serves channel reads
// and limit updates.
// ============================================================================
// Usage:
//   req/req_valid/req_ready carry command items (capture, read, set limits);
//   rsp/rsp_valid/rsp_ready return exactly one result item per command item.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the prescaler (index 0) and
//   the channel count (index 1); cfg_ready is always high. Write them only
//   while no item is in flight.
//   After the queue, a capture passes the two multiplier stages (S_MUL,
//   S_SCALE), a read whose percentage needs division runs S_PREP and the
//   20-step restoring divider, a read that needs no division runs S_PREP
//   only, and other items go straight to S_FIN. One item is executed at a
//   time, so a dividing read holds the execution unit longest and sets the
//   worst-case throughput.
//   A two-entry queue sits between the classifier and the execution unit,
//   so up to two further items are accepted while one executes.
//   Reset (synchronous, active high) restores prescaler 47, eight channels,
//   slot index zero, pulses zero and limits 700..1670 us, and empties the
//   queue. While the receiver holds rsp_ready low the result stays put, the
//   execution unit waits and the queue fills, then req_ready drops.
// ============================================================================
module ppm_frame_decoder import ppmfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  ppmfd_in_t  req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output ppmfd_out_t rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  // Configuration registers
  logic [7:0] prescaler;
  logic [3:0] channel_count;

  ppmfd_job_t     front_job;
  logic           q_valid;
  logic           q_ready;
  ppmfd_job_t     q_job;
  ppmfd_div_req_t div_req;
  ppmfd_div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;

  // Hold the register file; a write lands at once
  always_ff @(posedge clk) begin
    if (rst) begin
      prescaler     <= PRESCALER_RESET;
      channel_count <= CHANNEL_COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PRESCALER:     prescaler     <= cfg_data;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Classify the item and check its channel and limits
  ppmfd_front u_front (
    .req           (req),
    .channel_count (channel_count),
    .job           (front_job)
  );

  // Buffer classified items so intake and execution stall independently
  ppmfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (req_valid),
    .push_ready (req_ready),
    .push_item  (front_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_job)
  );

  // Execute one item at a time and register its result
  ppmfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_job     (q_job),
    .prescaler (prescaler),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Percentage division, one quotient bit per cycle
  ppmfd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

`ifndef SYNTHESIS
  a_ready_after_reset: assert property (@(posedge clk) rst |=> req_ready)
    else $error("queue not empty after reset");

  a_sync_result_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.frame_start |-> !rsp.status && rsp.percent == '0)
    else $error("sync gap result carries status or percentage");

  a_percent_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.percent <= 7'(PCT_FULL))
    else $error("percentage above full scale");

  a_error_result_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> rsp.pulse_us == '0 && rsp.percent == '0 &&
    !rsp.frame_start)
    else $error("error result carries data");
`endif

endmodule

>>> bench/ppmfd_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// ppmfd_checker - result checker for the PPM frame decoder
// Watches the command, result and register channels, predicts each result
// from its own copy of the decoder state and compares it field by field.
// ============================================================================
module ppmfd_checker import ppmfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_ready,
  input  ppmfd_in_t  req,
  input  logic       rsp_valid,
  input  logic       rsp_ready,
  input  ppmfd_out_t rsp,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output int         bad_results,
  output int         outstanding,
  output int         results_seen,
  output int         sync_gaps_seen,
  output int         reads_seen
);

  logic [7:0]                prescaler_q;
  logic [3:0]                count_q;
  int                        slot_q;
  logic signed [PULSE_W-1:0] width_mem [MAX_CHANNELS];
  logic [15:0]               floor_mem [MAX_CHANNELS];
  logic [15:0]               ceil_mem  [MAX_CHANNELS];

  ppmfd_out_t awaited_results [$];
  int         fail_cnt  = 0;
  int         check_cnt = 0;
  int         sync_cnt  = 0;
  int         read_cnt  = 0;

  // Truncated position between limits, clamped to 0..100.
  function automatic logic [6:0] position_pct(logic signed [PULSE_W-1:0] width,
                                              logic [15:0] lo, logic [15:0] hi);
    longint num;
    longint den;
    longint p;
    num = longint'(width) - longint'(lo);
    den = longint'(hi) - longint'(lo);
    if (num <= 0 || den <= 0) return 7'd0;
    p = (num * PCT_FULL) / den;
    return (p > PCT_FULL) ? 7'(PCT_FULL) : 7'(p);
  endfunction

  // Work out the result of one command and advance the decoder state.
  function automatic ppmfd_out_t decode_item(ppmfd_in_t it);
    ppmfd_out_t r;
    longint     us;
    logic       chan_valid;
    int         ch;
    r          = '0;
    ch         = int'(it.channel_index);
    chan_valid = (it.channel_index < count_q) && (ch < MAX_CHANNELS);
    case (ppmfd_op_t'(it.command))
      OP_CAPTURE: begin
        us = (longint'(it.capture_ticks) * (longint'(prescaler_q) + 1)) / BASE_MHZ
             - SYNC_OFFSET_US;
        if (us > SYNC_GAP_US) begin
          slot_q        = 0;
          r.frame_start = 1'b1;
        end else if (slot_q < MAX_CHANNELS) begin
          width_mem[slot_q] = PULSE_W'(us);
          slot_q++;
        end
        r.pulse_us = (us > PULSE_SAT) ? 17'(PULSE_SAT) : 17'(us);
      end
      OP_READ: begin
        if (chan_valid) begin
          r.pulse_us = {{(17 - PULSE_W){width_mem[ch][PULSE_W-1]}}, width_mem[ch]};
          r.percent  = position_pct(width_mem[ch], floor_mem[ch], ceil_mem[ch]);
        end else begin
          r.status = 1'b1;
        end
      end
      OP_LIMITS: begin
        if (chan_valid && it.limit_min < it.limit_max) begin
          floor_mem[ch] = it.limit_min;
          ceil_mem[ch]  = it.limit_max;
        end else begin
          r.status = 1'b1;
        end
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    ppmfd_out_t want;
    if (rst) begin
      prescaler_q = PRESCALER_RESET;
      count_q     = CHANNEL_COUNT_RESET;
      slot_q      = 0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        width_mem[i] = '0;
        floor_mem[i] = 16'(RESET_MIN_US);
        ceil_mem[i]  = 16'(RESET_MAX_US);
      end
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PRESCALER) prescaler_q = cfg_data;
        else                            count_q     = cfg_data[3:0];
      end
      // Compare before queueing, so a result never meets the item of this edge.
      if (rsp_valid && rsp_ready) begin
        check_cnt++;
        if (awaited_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result with nothing awaited: pulse %0d pct %0d st %0b fs %0b",
                     $time, rsp.pulse_us, rsp.percent, rsp.status, rsp.frame_start);
        end else begin
          want = awaited_results.pop_front();
          if (want.frame_start) sync_cnt++;
          if (rsp.pulse_us !== want.pulse_us || rsp.percent !== want.percent ||
              rsp.status !== want.status || rsp.frame_start !== want.frame_start) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: mismatch: expected pulse %0d pct %0d st %0b fs %0b,",
                       $time, want.pulse_us, want.percent, want.status,
                       want.frame_start,
                       " got pulse %0d pct %0d st %0b fs %0b",
                       rsp.pulse_us, rsp.percent, rsp.status, rsp.frame_start);
          end
        end
      end
      if (req_valid && req_ready) begin
        if (ppmfd_op_t'(req.command) == OP_READ) read_cnt++;
        awaited_results.push_back(decode_item(req));
      end
    end
    bad_results    <= fail_cnt;
    outstanding    <= awaited_results.size();
    results_seen   <= check_cnt;
    sync_gaps_seen <= sync_cnt;
    reads_seen     <= read_cnt;
  end

endmodule

>>> bench/ppm_frame_decoder_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// ppm_frame_decoder_tb - testbench for the PPM frame decoder
// Drives a directed burst and then random PPM frames, channel reads and limit
// updates under several register settings, with random idling on both sides;
// the checker beside the block predicts and compares every result.
// ============================================================================
module ppm_frame_decoder_tb;
  import ppmfd_pkg::*;

  localparam int N_PHASES       = 6;
  localparam int PHASE_ITEMS    = 300;
  localparam int CHUNK_ITEMS    = 100;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int TIMEOUT_CYCLES = 600_000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  ppmfd_in_t  req       = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  ppmfd_out_t rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = REG_PRESCALER;
  logic [7:0] cfg_data  = 8'd0;

  int bad_results;
  int outstanding;
  int results_seen;
  int sync_gaps_seen;
  int reads_seen;

  // Stimulus state; stalls_on and hold_cycles also steer the receiver process.
  bit gaps_on     = 1'b0;
  bit stalls_on   = 1'b0;
  int hold_cycles = 0;
  int cur_presc   = PRESCALER_RESET;
  int items_sent  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ppm_frame_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ppmfd_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .bad_results    (bad_results),
    .outstanding    (outstanding),
    .results_seen   (results_seen),
    .sync_gaps_seen (sync_gaps_seen),
    .reads_seen     (reads_seen)
  );

  // --------------------------------------------------------------------------
  // Item builders. Fields a command ignores carry random bits, so every bit of
  // the payload toggles even in the directed part.
  // --------------------------------------------------------------------------
  function automatic ppmfd_in_t noise_item();
    ppmfd_in_t it;
    it.command       = 2'($urandom_range(0, 3));
    it.capture_ticks = 16'($urandom);
    it.channel_index = 3'($urandom);
    it.limit_min     = 16'($urandom);
    it.limit_max     = 16'($urandom);
    return it;
  endfunction

  function automatic ppmfd_in_t capture_of(logic [15:0] ticks);
    ppmfd_in_t it;
    it               = noise_item();
    it.command       = OP_CAPTURE;
    it.capture_ticks = ticks;
    return it;
  endfunction

  function automatic ppmfd_in_t read_of(logic [2:0] ch);
    ppmfd_in_t it;
    it               = noise_item();
    it.command       = OP_READ;
    it.channel_index = ch;
    return it;
  endfunction

  function automatic ppmfd_in_t limits_of(logic [2:0] ch, logic [15:0] lo, logic [15:0] hi);
    ppmfd_in_t it;
    it               = noise_item();
    it.command       = OP_LIMITS;
    it.channel_index = ch;
    it.limit_min     = lo;
    it.limit_max     = hi;
    return it;
  endfunction

  // Tick count that gives roughly the wanted width at the current prescaler;
  // saturate where the 16-bit timer cannot reach it.
  function automatic logic [15:0] ticks_for_us(int us);
    longint t;
    t = (longint'(us) + SYNC_OFFSET_US) * BASE_MHZ / (cur_presc + 1);
    if (t < 0) t = 0;
    return (t > 65535) ? 16'hFFFF : 16'(t);
  endfunction

  // Channel pulse width: mostly servo-like, sometimes anywhere in range or
  // right at the sync threshold.
  function automatic int slot_width_us();
    case ($urandom_range(0, 9))
      0:       return int'($urandom_range(0, SYNC_GAP_US + SYNC_OFFSET_US)) - SYNC_OFFSET_US;
      1:       return SYNC_GAP_US - 1 + int'($urandom_range(0, 3));
      default: return int'($urandom_range(800, 2200));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one item, with an occasional idle burst first; hold valid high
  // afterwards so back-to-back items need no extra edge.
  task automatic offer(input ppmfd_in_t it);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= it;
    do @(posedge clk); while (!req_ready);
    items_sent++;
  endtask

  // Drop valid and wait until every awaited result has come back.
  task automatic quiesce();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed frames (sync gap, then channel pulses with reads mixed
  // in); the rest are stray reads, limit updates and noise.
  task automatic random_traffic(input int n_items);
    int done_cnt;
    int n_slots;
    int pick;
    logic [15:0] lo;
    logic [15:0] hi;
    ppmfd_in_t it;
    done_cnt = 0;
    while (done_cnt < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        offer(capture_of(ticks_for_us(int'($urandom_range(SYNC_GAP_US + 1,
                                                          4 * SYNC_GAP_US)))));
        n_slots  = $urandom_range(1, MAX_CHANNELS + 2);
        done_cnt += 1 + n_slots;
        repeat (n_slots) begin
          offer(capture_of(ticks_for_us(slot_width_us())));
          if ($urandom_range(0, 3) == 0) begin
            offer(read_of(3'($urandom_range(0, MAX_CHANNELS - 1))));
            done_cnt++;
          end
        end
      end else if (pick < 78) begin
        offer(read_of(3'($urandom)));
        done_cnt++;
      end else if (pick < 90) begin
        if ($urandom_range(0, 3) != 0) begin
          lo = 16'($urandom_range(600, 1200));
          hi = lo + 16'($urandom_range(1, 1500));
        end else begin
          lo = 16'($urandom);
          hi = ($urandom_range(0, 3) == 0) ? lo : 16'($urandom);
        end
        offer(limits_of(3'($urandom), lo, hi));
        done_cnt++;
      end else if (pick < 97) begin
        offer(capture_of(16'($urandom)));
        done_cnt++;
      end else begin
        it = noise_item();
        if ($urandom_range(0, 1) == 0) it.command = OP_BAD;
        offer(it);
        done_cnt++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stall bursts, plus one long hold on request. The
  // long hold is counted here so the sender can keep pushing into the block.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        rsp_ready  <= 1'b0;
        repeat (n) @(posedge clk);
        rsp_ready  <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        n          = $urandom_range(1, 7);
        rsp_ready <= 1'b0;
        repeat (n) @(posedge clk);
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int presc_tab [N_PHASES];
    int count_tab [N_PHASES];
    presc_tab = '{47, 255, 0, 11, 0, 47};
    count_tab = '{8, 1, 8, 4, 0, 6};
    presc_tab[4] = $urandom_range(1, 254);
    count_tab[4] = $urandom_range(1, 8);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings: prescaler 47 makes ticks minus 310 the
    // width in microseconds, so the thresholds can be hit exactly.
    offer(read_of(3'd0));                      // untouched slot reads zero
    offer(capture_of(16'd0));                  // most negative width, slot 0
    offer(capture_of(16'(SYNC_GAP_US + SYNC_OFFSET_US + 1)));  // just a sync gap
    offer(capture_of(16'(SYNC_GAP_US + SYNC_OFFSET_US)));      // just not one
    // fill the rest of the frame: at the minimum, at the maximum, between,
    // above the maximum and just below the minimum
    offer(capture_of(16'(RESET_MIN_US + SYNC_OFFSET_US)));
    offer(capture_of(16'(RESET_MAX_US + SYNC_OFFSET_US)));
    offer(capture_of(16'(1185 + SYNC_OFFSET_US)));
    offer(capture_of(16'(2000 + SYNC_OFFSET_US)));
    offer(capture_of(16'(1000 + SYNC_OFFSET_US)));
    offer(capture_of(16'(1500 + SYNC_OFFSET_US)));
    offer(capture_of(16'(RESET_MIN_US - 1 + SYNC_OFFSET_US)));
    offer(capture_of(16'(1310)));              // past the last slot: drop
    offer(capture_of(16'hFFFF));               // widest gap
    for (int ch = 0; ch < MAX_CHANNELS; ch++)
      offer(read_of(3'(ch)));
    offer(limits_of(3'd7, 16'd0, 16'hFFFF));   // widest limits
    offer(limits_of(3'd6, 16'd1500, 16'd1500)); // min not below max
    offer(limits_of(3'd5, 16'hFFFF, 16'd0));
    offer(read_of(3'd7));
    begin
      ppmfd_in_t it;
      it = noise_item();
      it.command = OP_BAD;
      offer(it);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_PRESCALER, 8'(presc_tab[p]));
      write_reg(REG_CHANNEL_COUNT, 8'(count_tab[p]));
      cur_presc = presc_tab[p];
      for (int c = 0; c < PHASE_ITEMS / CHUNK_ITEMS; c++) begin
        // last phase runs flat out; elsewhere idle at random per chunk
        gaps_on   = (p != N_PHASES - 1) && ($urandom_range(0, 2) != 0);
        stalls_on = (p != N_PHASES - 1) && ($urandom_range(0, 2) != 0);
        if (p == 1 && c == 0) begin
          // hold the receiver off and keep offering until the input stalls
          gaps_on     = 1'b0;
          hold_cycles = LONG_HOLD;
        end
        if (p == 3 && c == 1) quiesce();
        random_traffic(CHUNK_ITEMS);
      end
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items over %0d register settings: %0d results checked,",
             items_sent, N_PHASES + 1, results_seen);
    $display("including %0d sync gaps and %0d channel reads.", sync_gaps_seen, reads_seen);
    if (bad_results == 0) begin
      $display("[ppm_frame_decoder] OK");
    end else begin
      $display("[ppm_frame_decoder] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 12);
    $display("Run stopped: no progress within the time limit.");
    $display("[ppm_frame_decoder] ERROR");
    $finish;
  end

endmodule
